// ===== hw/rtl/pulse_width_remote_decoder_core_defines.svh =====
// Assertion macros used by the decoder checker.
// No dependencies.
`ifndef PULSE_WIDTH_REMOTE_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_REMOTE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pwrd_pkg.sv =====
// Types and constants of the pulse-width remote decoder.
// No dependencies.
package pwrd_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUR_W  = 16;
	localparam int unsigned CNT_W  = 3;

	typedef enum logic [1:0] {
		CODE_NONE  = 2'd0,
		CODE_OPEN  = 2'd1,
		CODE_CLOSE = 2'd2,
		CODE_STOP  = 2'd3
	} code_t;

	typedef enum logic [2:0] {
		REG_OPEN_DURATION  = 3'd0,
		REG_CLOSE_DURATION = 3'd1,
		REG_STOP_DURATION  = 3'd2,
		REG_WINDOW_MARGIN  = 3'd3,
		REG_SYNC_MIN       = 3'd4,
		REG_SYNC_MAX       = 3'd5,
		REG_REPEATS_NEEDED = 3'd6
	} reg_idx_t;

	localparam logic [DUR_W-1:0] RST_OPEN_DURATION  = 16'd0;
	localparam logic [DUR_W-1:0] RST_CLOSE_DURATION = 16'd0;
	localparam logic [DUR_W-1:0] RST_STOP_DURATION  = 16'd0;
	localparam logic [DUR_W-1:0] RST_WINDOW_MARGIN  = 16'd1000;
	localparam logic [DUR_W-1:0] RST_SYNC_MIN       = 16'd3500;
	localparam logic [DUR_W-1:0] RST_SYNC_MAX       = 16'd4500;
	localparam logic [CNT_W-1:0] RST_REPEATS_NEEDED = 3'd3;

	typedef struct packed {
		logic              cmd;
		logic              pin_level;
		logic [TIME_W-1:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0] latched_code;
		logic       code_pending;
	} out_item_t;

	typedef struct packed {
		logic [2:0]       index;
		logic [DUR_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [DUR_W-1:0] open_duration;
		logic [DUR_W-1:0] close_duration;
		logic [DUR_W-1:0] stop_duration;
		logic [DUR_W-1:0] window_margin;
		logic [DUR_W-1:0] sync_min;
		logic [DUR_W-1:0] sync_max;
		logic [CNT_W-1:0] repeats_needed;
	} cfg_t;

endpackage

// ===== hw/rtl/pwrd_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Payload type is supplied by the instantiating scope.
interface pwrd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pwrd_cfg_regs.sv =====
// Configuration register file of the remote decoder.
// Depends on pwrd_pkg.
module pwrd_cfg_regs
	import pwrd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  cfg_wr_t wr,
	output cfg_t    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_duration  <= RST_OPEN_DURATION;
			cfg_q.close_duration <= RST_CLOSE_DURATION;
			cfg_q.stop_duration  <= RST_STOP_DURATION;
			cfg_q.window_margin  <= RST_WINDOW_MARGIN;
			cfg_q.sync_min       <= RST_SYNC_MIN;
			cfg_q.sync_max       <= RST_SYNC_MAX;
			cfg_q.repeats_needed <= RST_REPEATS_NEEDED;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr.index))
				REG_OPEN_DURATION:  cfg_q.open_duration  <= wr.data;
				REG_CLOSE_DURATION: cfg_q.close_duration <= wr.data;
				REG_STOP_DURATION:  cfg_q.stop_duration  <= wr.data;
				REG_WINDOW_MARGIN:  cfg_q.window_margin  <= wr.data;
				REG_SYNC_MIN:       cfg_q.sync_min       <= wr.data;
				REG_SYNC_MAX:       cfg_q.sync_max       <= wr.data;
				REG_REPEATS_NEEDED: cfg_q.repeats_needed <= wr.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pwrd_decode.sv =====
// Edge tracker, pulse classifier and code latch of the remote decoder.
// Depends on pwrd_pkg.
module pwrd_decode
	import pwrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic              last_level_q;
	logic [TIME_W-1:0] high_start_q;
	logic              high_valid_q;
	logic [TIME_W-1:0] low_start_q;
	logic              low_valid_q;
	code_t             cand_q;
	logic [CNT_W-1:0]  cnt_q;
	code_t             held_q;

	logic              last_level_n;
	logic [TIME_W-1:0] high_start_n;
	logic              high_valid_n;
	logic [TIME_W-1:0] low_start_n;
	logic              low_valid_n;
	code_t             cand_n;
	logic [CNT_W-1:0]  cnt_n;
	code_t             held_n;

	logic [TIME_W-1:0] pulse_len;
	logic [DUR_W:0]    open_hi, close_hi, stop_hi;
	logic              in_open, in_close, in_stop, sync_bad, check;
	code_t             low_code;

	assign pulse_len = item.time_us - (item.pin_level ? low_start_q : high_start_q);

	assign open_hi  = {1'b0, cfg.open_duration} + {1'b0, cfg.window_margin};
	assign close_hi = {1'b0, cfg.close_duration} + {1'b0, cfg.window_margin};
	assign stop_hi  = {1'b0, cfg.stop_duration} + {1'b0, cfg.window_margin};

	assign in_open  = (pulse_len >= {16'd0, cfg.open_duration})
		&& (pulse_len <= {15'd0, open_hi});
	assign in_close = (pulse_len >= {16'd0, cfg.close_duration})
		&& (pulse_len <= {15'd0, close_hi});
	assign in_stop  = (pulse_len >= {16'd0, cfg.stop_duration})
		&& (pulse_len <= {15'd0, stop_hi});

	assign sync_bad = (pulse_len < {16'd0, cfg.sync_min})
		|| (pulse_len > {16'd0, cfg.sync_max});

	always_comb begin
		priority if (in_open) begin
			low_code = CODE_OPEN;
		end else if (in_close) begin
			low_code = CODE_CLOSE;
		end else if (in_stop) begin
			low_code = CODE_STOP;
		end else begin
			low_code = CODE_NONE;
		end
	end

	always_comb begin
		last_level_n = last_level_q;
		high_start_n = high_start_q;
		high_valid_n = high_valid_q;
		low_start_n  = low_start_q;
		low_valid_n  = low_valid_q;
		cand_n       = cand_q;
		cnt_n        = cnt_q;
		held_n       = held_q;
		check        = 1'b0;
		result.latched_code = held_q;

		if (item.cmd) begin
			held_n = CODE_NONE;
		end else if (item.pin_level != last_level_q) begin
			last_level_n = item.pin_level;
			if (!item.pin_level) begin
				low_start_n = item.time_us;
				low_valid_n = 1'b1;
				check       = high_valid_q;
				if (high_valid_q && sync_bad) begin
					cand_n = CODE_NONE;
					cnt_n  = '0;
				end
			end else begin
				high_start_n = item.time_us;
				high_valid_n = 1'b1;
				check        = low_valid_q;
				if (low_valid_q) begin
					if (low_code == CODE_NONE
						|| (cand_q != CODE_NONE && cand_q != low_code)) begin
						cand_n = CODE_NONE;
						cnt_n  = '0;
					end else if (cand_q == CODE_NONE) begin
						cand_n = low_code;
						cnt_n  = CNT_W'(1);
					end else begin
						cnt_n = cnt_q + CNT_W'(1);
					end
				end
			end
			if (check && cnt_n >= cfg.repeats_needed) begin
				held_n = cand_n;
				cand_n = CODE_NONE;
				cnt_n  = '0;
			end
		end

		if (!item.cmd) begin
			result.latched_code = held_n;
		end
		result.code_pending = (held_n != CODE_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			high_start_q <= '0;
			high_valid_q <= 1'b0;
			low_start_q  <= '0;
			low_valid_q  <= 1'b0;
			cand_q       <= CODE_NONE;
			cnt_q        <= '0;
			held_q       <= CODE_NONE;
		end else if (advance) begin
			last_level_q <= last_level_n;
			high_start_q <= high_start_n;
			high_valid_q <= high_valid_n;
			low_start_q  <= low_start_n;
			low_valid_q  <= low_valid_n;
			cand_q       <= cand_n;
			cnt_q        <= cnt_n;
			held_q       <= held_n;
		end
	end

endmodule

// ===== hw/rtl/pulse_width_remote_decoder_core.sv =====
// Pulse-width remote code decoder, top level.
// An item passes the stage register, then the result register, before its result can transfer.
// Throughput: one item per cycle while results are taken; the decode state is updated on each advance.
// A waiting result lets one more item into the stage register, then stalls the input.
// Reset (arst_n low, asynchronous) clears pipeline valids and decode state and reloads config defaults.
// Depends on pwrd_pkg, pwrd_chan_if, pwrd_cfg_regs, pwrd_decode.
module pulse_width_remote_decoder_core
	import pwrd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	pwrd_chan_if.sink   items,
	pwrd_chan_if.source results,
	pwrd_chan_if.sink   cfg
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      res_valid_q;
	out_item_t result;
	cfg_t      cfg_regs;
	logic      advance;

	assign advance       = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready   = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;
	assign results.valid = res_valid_q;
	assign results.payload = res_q;

	pwrd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg.valid),
		.wr     (cfg.payload),
		.cfg    (cfg_regs)
	);

	pwrd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_regs),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.payload;
		end
		if (advance) begin
			res_q <= result;
		end
	end

endmodule

// ===== hw/rtl/pwrd_checker.sv =====
// Port-level checks of the remote decoder, bound to the top level.
// Depends on pwrd_pkg and pulse_width_remote_decoder_core_defines.svh.
`include "pulse_width_remote_decoder_core_defines.svh"

module pwrd_checker
	import pwrd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      items_ready,
	input logic      results_valid,
	input logic      results_ready,
	input out_item_t results_payload
);

	`PWRD_ASSERT_NEXT(a_result_hold, clk, arst_n, results_valid && !results_ready, results_valid && $stable(results_payload), "stalled result changed")

	`PWRD_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !items_ready, results_valid, "input stalled without a waiting result")

	`PWRD_ASSERT_IMPLY(a_pending_code, clk, arst_n, results_valid && results_payload.code_pending, results_payload.latched_code != CODE_NONE, "pending flag without a latched code")

endmodule

bind pulse_width_remote_decoder_core pwrd_checker u_pwrd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.items_ready     (items.ready),
	.results_valid   (results.valid),
	.results_ready   (results.ready),
	.results_payload (results.payload)
);
